[hdl/multichannel_pcm_sample_mixer_assert.svh]
// Assertion macros for the sample mixer.
`ifndef MULTICHANNEL_PCM_SAMPLE_MIXER_ASSERT_SVH
`define MULTICHANNEL_PCM_SAMPLE_MIXER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MPSM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mixer assertion failed");
// next-cycle implication
`define MPSM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mixer assertion failed");
`else
`define MPSM_ASSERT_IMP(label, ante, cons)
`define MPSM_ASSERT_NXT(label, ante, cons)
`endif
`endif

[hdl/mpsm_pkg.sv]
`default_nettype none
package mpsm_pkg;
	localparam int VOICES       = 8;
	localparam int VIDX_W       = $clog2(VOICES);
	localparam int SAMPLE_WORDS = 65536;
	localparam int MEM_AW       = $clog2(SAMPLE_WORDS);
	// accumulator: per-voice term below 2^15, summed over all voices
	localparam int ACC_W        = 16 + VIDX_W;

	localparam logic [16:0] MAX_LENGTH   = 17'd65536;
	localparam logic [15:0] HANDLE_FIRST = 16'd100;
	// divide by 127: multiply by floor(2^29/127), then one correction step
	localparam logic [22:0] DIV_RECIP    = 23'd4227330;
	localparam int          DIV_SHIFT    = 29;
	localparam logic [22:0] DIVISOR      = 23'd127;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_START = 2'd1,
		REQ_MIX   = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef struct packed {
		logic capture;
		logic mem_write;
		logic stop;
		logic scan_step;
		logic gain_sq;
		logic gain_mul;
		logic load;
		logic mix_read;
		logic mix_skip;
		logic mix_mul;
		logic mix_div;
		logic mix_acc;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic cur_active;
		logic last_voice;
	} sts_t;
endpackage
`default_nettype wire

[hdl/mpsm_ctrl.sv]
`default_nettype none
module mpsm_ctrl import mpsm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_DISP  = 13'b0000000000010,
		S_WRITE = 13'b0000000000100,
		S_STOP  = 13'b0000000001000,
		S_SCAN  = 13'b0000000010000,
		S_GSQ   = 13'b0000000100000,
		S_GMUL  = 13'b0000001000000,
		S_LOAD  = 13'b0000010000000,
		S_MRD   = 13'b0000100000000,
		S_MMUL  = 13'b0001000000000,
		S_MDIV  = 13'b0010000000000,
		S_MACC  = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.req)
					REQ_WRITE: state_d = S_WRITE;
					REQ_START: state_d = S_STOP;
					REQ_MIX:   state_d = S_MRD;
					default:   state_d = S_DONE;
				endcase
			end
			S_WRITE: begin
				cmd.mem_write = 1'b1;
				state_d       = S_DONE;
			end
			S_STOP: begin
				cmd.stop = 1'b1;
				state_d  = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.last_voice) state_d = S_GSQ;
			end
			S_GSQ: begin
				cmd.gain_sq = 1'b1;
				state_d     = S_GMUL;
			end
			S_GMUL: begin
				cmd.gain_mul = 1'b1;
				state_d      = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_DONE;
			end
			S_MRD: begin
				if (sts.cur_active) begin
					cmd.mix_read = 1'b1;
					state_d      = S_MMUL;
				end else begin
					cmd.mix_skip = 1'b1;
					if (sts.last_voice) state_d = S_DONE;
				end
			end
			S_MMUL: begin
				cmd.mix_mul = 1'b1;
				state_d     = S_MDIV;
			end
			S_MDIV: begin
				cmd.mix_div = 1'b1;
				state_d     = S_MACC;
			end
			S_MACC: begin
				cmd.mix_acc = 1'b1;
				state_d     = sts.last_voice ? S_DONE : S_MRD;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.result_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result_load) out_valid_q <= 1'b1;
			else if (out_ready)  out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

[hdl/mpsm_dp.sv]
`default_nettype none
module mpsm_dp import mpsm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] mem_addr,
	input  wire logic [7:0]  mem_byte,
	input  wire logic [7:0]  sound_id,
	input  wire logic        one_at_a_time,
	input  wire logic [15:0] sound_start,
	input  wire logic [16:0] sound_length,
	input  wire logic [3:0]  volume,
	input  wire logic [17:0] pitch_step,
	input  wire logic [7:0]  separation,
	input  wire logic [30:0] current_tick,
	output logic [15:0]      handle,
	output logic [15:0]      left_sample,
	output logic [15:0]      right_sample
);
	// captured request
	req_t        req_q;
	logic [15:0] addr_q, start_q;
	logic [7:0]  byte_q, sid_q, sep_q;
	logic        oaat_q;
	logic [16:0] len_q;
	logic [3:0]  vol_q;
	logic [17:0] step_q;
	logic [30:0] tick_q;

	// voice table
	logic [VOICES-1:0] active_q;
	logic [16:0] pos_q   [VOICES];
	logic [16:0] end_q   [VOICES];
	logic [15:0] frac_q  [VOICES];
	logic [17:0] vstep_q [VOICES];
	logic [6:0]  gl_q    [VOICES];
	logic [6:0]  gr_q    [VOICES];
	logic [7:0]  snd_q   [VOICES];
	logic [30:0] vtick_q [VOICES];
	logic [15:0] hcnt_q;

	logic [VIDX_W-1:0] idx_q;
	logic              last_voice;

	logic [7:0] mem [SAMPLE_WORDS];
	logic [7:0] rd_q;

	assign last_voice     = (idx_q == VIDX_W'(VOICES - 1));
	assign sts.req        = req_q;
	assign sts.cur_active = active_q[idx_q];
	assign sts.last_voice = last_voice;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_t'(req_type);
			addr_q  <= mem_addr;
			byte_q  <= mem_byte;
			sid_q   <= sound_id;
			oaat_q  <= one_at_a_time;
			start_q <= sound_start;
			len_q   <= sound_length;
			vol_q   <= volume;
			step_q  <= pitch_step;
			sep_q   <= separation;
			tick_q  <= current_tick;
		end
	end

	// sample memory, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.mem_write) mem[addr_q[MEM_AW-1:0]] <= byte_q;
		if (cmd.mix_read)  rd_q <= mem[pos_q[idx_q][MEM_AW-1:0]];
	end

	// voice index walks the table for both scan and mix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.capture) begin
			idx_q <= '0;
		end else if (cmd.scan_step || cmd.mix_skip || cmd.mix_acc) begin
			idx_q <= last_voice ? '0 : idx_q + 1'b1;
		end
	end

	// lowest active voice already playing this sound
	logic              stop_hit;
	logic [VIDX_W-1:0] stop_idx;
	always_comb begin
		stop_hit = 1'b0;
		stop_idx = '0;
		for (int i = 0; i < VOICES; i++) begin
			if (!stop_hit && active_q[i] && snd_q[i] == sid_q) begin
				stop_hit = 1'b1;
				stop_idx = VIDX_W'(i);
			end
		end
	end

	// free or oldest voice search
	logic              found_q;
	logic [VIDX_W-1:0] slot_q, old_idx_q, slot;
	logic [30:0]       oldest_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			found_q   <= 1'b0;
			oldest_q  <= current_tick;
			old_idx_q <= '0;
		end else if (cmd.scan_step && !found_q) begin
			if (!active_q[idx_q]) begin
				found_q <= 1'b1;
				slot_q  <= idx_q;
			end else if (vtick_q[idx_q] < oldest_q) begin
				oldest_q  <= vtick_q[idx_q];
				old_idx_q <= idx_q;
			end
		end
	end
	assign slot = found_q ? slot_q : old_idx_q;

	// pan gains in two multiply steps
	logic [8:0]  sep_p1, sep_r;
	logic [6:0]  vol8;
	logic [16:0] sql_q, sqr_q;
	logic [23:0] pl, pr;
	logic [6:0]  new_gl_q, new_gr_q;
	assign sep_p1 = {1'b0, sep_q} + 9'd1;
	assign sep_r  = 9'd257 - sep_p1;
	assign vol8   = {vol_q, 3'b000};
	assign pl     = 24'(vol8) * 24'(sql_q);
	assign pr     = 24'(vol8) * 24'(sqr_q);
	always_ff @(posedge clk) begin
		if (cmd.gain_sq) begin
			sql_q <= 17'(sep_p1) * 17'(sep_p1);
			sqr_q <= 17'(sep_r) * 17'(sep_r);
		end
		if (cmd.gain_mul) begin
			new_gl_q <= vol8 - pl[22:16];
			new_gr_q <= vol8 - pr[22:16];
		end
	end

	// voice end with length clamp, next handle
	logic [16:0] len_sat, end_v;
	logic [15:0] hval;
	logic [15:0] handle_res_q;
	assign len_sat = (len_q > MAX_LENGTH) ? MAX_LENGTH : len_q;
	assign end_v   = {1'b0, start_q} + len_sat;
	assign hval    = (hcnt_q == '0) ? HANDLE_FIRST : hcnt_q;

	// mix arithmetic: |gain*(b-128)|, then *256/127 truncated, sign applied
	logic              neg_s1;
	logic [14:0]       al_s1, ar_s1;
	logic [22:0]       xl, xr, ql_s2, qr_s2, reml, remr, ql, qr;
	logic [45:0]       prl, prr;
	logic [7:0]        mag;
	logic signed [ACC_W-1:0] accl_q, accr_q;
	logic [18:0]       fsum;
	logic [17:0]       npos;
	assign mag  = rd_q[7] ? {1'b0, rd_q[6:0]} : 8'd128 - rd_q;
	assign xl   = {al_s1, 8'b0};
	assign xr   = {ar_s1, 8'b0};
	assign prl  = 46'(xl) * 46'(DIV_RECIP);
	assign prr  = 46'(xr) * 46'(DIV_RECIP);
	assign reml = xl - 23'(ql_s2 * DIVISOR);
	assign remr = xr - 23'(qr_s2 * DIVISOR);
	assign ql   = ql_s2 + ((reml >= DIVISOR) ? 23'd1 : 23'd0);
	assign qr   = qr_s2 + ((remr >= DIVISOR) ? 23'd1 : 23'd0);
	assign fsum = {3'b000, frac_q[idx_q]} + {1'b0, vstep_q[idx_q]};
	assign npos = {1'b0, pos_q[idx_q]} + 18'(fsum[18:16]);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			accl_q <= '0;
			accr_q <= '0;
		end
		if (cmd.mix_mul) begin
			neg_s1 <= !rd_q[7];
			al_s1  <= 15'(gl_q[idx_q]) * 15'(mag);
			ar_s1  <= 15'(gr_q[idx_q]) * 15'(mag);
		end
		if (cmd.mix_div) begin
			ql_s2 <= 23'(prl >> DIV_SHIFT);
			qr_s2 <= 23'(prr >> DIV_SHIFT);
		end
		if (cmd.mix_acc) begin
			accl_q <= neg_s1 ? accl_q - ACC_W'(ql) : accl_q + ACC_W'(ql);
			accr_q <= neg_s1 ? accr_q - ACC_W'(qr) : accr_q + ACC_W'(qr);
		end
	end

	// voice table writes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q[slot]   <= {1'b0, start_q};
			end_q[slot]   <= end_v;
			frac_q[slot]  <= '0;
			vstep_q[slot] <= step_q;
			gl_q[slot]    <= new_gl_q;
			gr_q[slot]    <= new_gr_q;
			snd_q[slot]   <= sid_q;
			vtick_q[slot] <= tick_q;
			handle_res_q  <= hval;
		end
		if (cmd.mix_acc) begin
			frac_q[idx_q] <= fsum[15:0];
			pos_q[idx_q]  <= npos[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			hcnt_q   <= '0;
		end else begin
			if (cmd.stop && oaat_q && stop_hit) active_q[stop_idx] <= 1'b0;
			if (cmd.load) begin
				active_q[slot] <= 1'b1;
				hcnt_q         <= hval + 16'd1;
			end
			if (cmd.mix_acc && npos >= {1'b0, end_q[idx_q]}) active_q[idx_q] <= 1'b0;
		end
	end

	// saturation and result register
	function automatic logic [15:0] sat16(input logic signed [ACC_W-1:0] x);
		if (x > ACC_W'(32767))       sat16 = 16'h7fff;
		else if (x < -ACC_W'(32768)) sat16 = 16'h8000;
		else                         sat16 = x[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			handle       <= '0;
			left_sample  <= '0;
			right_sample <= '0;
			case (req_q)
				REQ_START: handle <= handle_res_q;
				REQ_MIX: begin
					left_sample  <= sat16(accl_q);
					right_sample <= sat16(accr_q);
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

[hdl/multichannel_pcm_sample_mixer.sv]
// One request at a time: the next transaction is taken the cycle after the
// result is loaded, so a new request is taken only once the last is through.
// Reset (arst_n low) clears the sequencer, voice active flags, the handle
// counter and output valid; sample memory and voice parameters are not cleared.
`default_nettype none
`include "multichannel_pcm_sample_mixer_assert.svh"
module multichannel_pcm_sample_mixer import mpsm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] mem_addr,
	input  wire logic [7:0]  mem_byte,
	input  wire logic [7:0]  sound_id,
	input  wire logic        one_at_a_time,
	input  wire logic [15:0] sound_start,
	input  wire logic [16:0] sound_length,
	input  wire logic [3:0]  volume,
	input  wire logic [17:0] pitch_step,
	input  wire logic [7:0]  separation,
	input  wire logic [30:0] current_tick,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      handle,
	output logic [15:0]      left_sample,
	output logic [15:0]      right_sample
);
	cmd_t cmd;
	sts_t sts;

	mpsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mpsm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.mem_addr      (mem_addr),
		.mem_byte      (mem_byte),
		.sound_id      (sound_id),
		.one_at_a_time (one_at_a_time),
		.sound_start   (sound_start),
		.sound_length  (sound_length),
		.volume        (volume),
		.pitch_step    (pitch_step),
		.separation    (separation),
		.current_tick  (current_tick),
		.handle        (handle),
		.left_sample   (left_sample),
		.right_sample  (right_sample)
	);

	// a taken transaction keeps the block busy for at least the next cycle
	`MPSM_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// a start result carries no audio
	`MPSM_ASSERT_IMP(a_handle_no_audio, out_valid && handle != '0, (left_sample | right_sample) == '0)
	// handles never fall below the first handle value
	`MPSM_ASSERT_IMP(a_handle_floor, out_valid && handle != '0, handle >= HANDLE_FIRST)
endmodule
`default_nettype wire

[bench/testbench.sv]
`default_nettype none
module testbench import mpsm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		req_t        req;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [7:0]  sid;
		logic        solo;
		logic [15:0] sstart;
		logic [16:0] slen;
		logic [3:0]  vol;
		logic [17:0] pstep;
		logic [7:0]  sep;
		logic [30:0] tick;
	} mix_req_t;

	typedef struct {
		logic [15:0] handle;
		logic [15:0] left;
		logic [15:0] right;
	} frame_t;

	localparam logic [15:0] WIN_BASE = 16'hFF80;
	localparam int          WIN_SIZE = 256;
	localparam int          RAND_REQS = 875;
	localparam int          STALL_LIMIT = 2000;
	localparam int          DRAIN_CYCLES = 60;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [15:0] handle, left_sample, right_sample;
	mix_req_t drv;

	multichannel_pcm_sample_mixer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(drv.req), .mem_addr(drv.addr), .mem_byte(drv.data),
		.sound_id(drv.sid), .one_at_a_time(drv.solo),
		.sound_start(drv.sstart), .sound_length(drv.slen),
		.volume(drv.vol), .pitch_step(drv.pstep), .separation(drv.sep),
		.current_tick(drv.tick),
		.out_valid(out_valid), .out_ready(out_ready),
		.handle(handle), .left_sample(left_sample), .right_sample(right_sample)
	);

	mix_req_t    req_q[$];
	frame_t      frame_expect_q[$];
	mix_req_t    cur_req;
	int          err_cnt = 0;
	int          sent_cnt = 0;
	int          stall_cnt = 0;
	int unsigned tick_now = 1000;

	// mirror of the mixer state
	logic [7:0]  smem [0:65535];
	logic        v_act [VOICES];
	int unsigned v_pos [VOICES];
	int unsigned v_end [VOICES];
	int unsigned v_frac [VOICES];
	int unsigned v_step [VOICES];
	int unsigned v_lg [VOICES];
	int unsigned v_rg [VOICES];
	logic [7:0]  v_sid [VOICES];
	int unsigned v_tick [VOICES];
	int unsigned handle_cnt = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] clamp16(int x);
		if (x > 32767)
			x = 32767;
		else if (x < -32768)
			x = -32768;
		return x[15:0];
	endfunction

	// expected result of one request; updates the mirrored state
	function automatic frame_t mixer_predict(mix_req_t r);
		frame_t      f;
		int          l, rr, b, i, slot;
		int unsigned oldest, oldest_i, v, s, d, len;
		f = '{16'd0, 16'd0, 16'd0};
		case (r.req)
			REQ_WRITE: smem[r.addr] = r.data;
			REQ_START: begin
				if (r.solo) begin
					for (i = 0; i < VOICES; i++)
						if (v_act[i] && v_sid[i] == r.sid) begin
							v_act[i] = 0;
							break;
						end
				end
				oldest = r.tick;
				oldest_i = 0;
				for (i = 0; i < VOICES && v_act[i]; i++)
					if (v_tick[i] < oldest) begin
						oldest = v_tick[i];
						oldest_i = i;
					end
				slot = (i == VOICES) ? oldest_i : i;
				len = (r.slen > MAX_LENGTH) ? MAX_LENGTH : r.slen;
				v = r.vol * 8;
				s = r.sep + 1;
				d = 257 - s;
				v_act[slot] = 1;
				v_pos[slot] = r.sstart;
				v_end[slot] = r.sstart + len;
				v_frac[slot] = 0;
				v_step[slot] = r.pstep;
				v_tick[slot] = r.tick;
				v_sid[slot] = r.sid;
				v_lg[slot] = v - ((v * s * s) >> 16);
				v_rg[slot] = v - ((v * d * d) >> 16);
				if (handle_cnt == 0)
					handle_cnt = HANDLE_FIRST;
				f.handle = handle_cnt[15:0];
				handle_cnt = (handle_cnt + 1) & 32'hFFFF;
			end
			REQ_MIX: begin
				l = 0;
				rr = 0;
				for (i = 0; i < VOICES; i++) begin
					if (!v_act[i])
						continue;
					b = smem[v_pos[i][15:0]];
					l += (int'(v_lg[i]) * (b - 128) * 256) / 127;
					rr += (int'(v_rg[i]) * (b - 128) * 256) / 127;
					v_frac[i] += v_step[i];
					v_pos[i] += v_frac[i] >> 16;
					v_frac[i] &= 32'hFFFF;
					if (v_pos[i] >= v_end[i])
						v_act[i] = 0;
				end
				f.left = clamp16(l);
				f.right = clamp16(rr);
			end
			default: ;
		endcase
		return f;
	endfunction

	function automatic mix_req_t noise_req();
		mix_req_t r;
		r.req = req_t'($urandom_range(3));
		r.addr = $urandom;
		r.data = $urandom;
		r.sid = $urandom;
		r.solo = $urandom;
		r.sstart = $urandom;
		r.slen = $urandom;
		r.vol = $urandom;
		r.pstep = $urandom;
		r.sep = $urandom;
		r.tick = $urandom;
		return r;
	endfunction

	function automatic void push_write(logic [15:0] a, logic [7:0] d);
		mix_req_t r;
		r = noise_req();
		r.req = REQ_WRITE;
		r.addr = a;
		r.data = d;
		req_q.push_back(r);
	endfunction

	// sounds stay inside the prefilled window so no unwritten byte is read
	function automatic void push_start(logic [7:0] sid, logic solo, int off, logic [16:0] len,
			logic [3:0] vol, logic [17:0] pstep, logic [7:0] sep, logic [30:0] tick);
		mix_req_t r;
		r = noise_req();
		r.req = REQ_START;
		r.sid = sid;
		r.solo = solo;
		r.sstart = WIN_BASE + off;
		r.slen = len;
		r.vol = vol;
		r.pstep = pstep;
		r.sep = sep;
		r.tick = tick;
		req_q.push_back(r);
	endfunction

	function automatic void push_kind(req_t k);
		mix_req_t r;
		r = noise_req();
		r.req = k;
		req_q.push_back(r);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		int idle_pct;
		if (!arst_n) begin
			in_valid <= 0;
			drv <= '{REQ_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		end else begin
			idle_pct = ((sent_cnt / 100) % 4 == 1) ? 74 : ((sent_cnt / 100) % 4 == 3) ? 6 : 0;
			if (in_valid && in_ready)
				frame_expect_q.push_back(mixer_predict(cur_req));
			if (!in_valid || in_ready) begin
				if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					cur_req = req_q.pop_front();
					sent_cnt++;
					drv <= cur_req;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// monitor, scoreboard and watchdog
	always @(posedge clk or negedge arst_n) begin
		int     stall_pct;
		frame_t e;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			stall_pct = ((sent_cnt / 100) % 4 == 2) ? 74 : ((sent_cnt / 100) % 4 == 3) ? 6 : 0;
			out_ready <= ($urandom_range(99) >= stall_pct);
			if (out_valid && out_ready) begin
				if (frame_expect_q.size() == 0) begin
					err_cnt++;
					$display("%t: unexpected transaction h=%0d l=%0d r=%0d", $realtime,
						handle, $signed(left_sample), $signed(right_sample));
				end else begin
					e = frame_expect_q.pop_front();
					if (e.handle !== handle || e.left !== left_sample || e.right !== right_sample) begin
						err_cnt++;
						if (err_cnt <= 50)
							$display("%t: expected h=%0d l=%0d r=%0d, actual h=%0d l=%0d r=%0d",
								$realtime, e.handle, $signed(e.left), $signed(e.right),
								handle, $signed(left_sample), $signed(right_sample));
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int off, k, pick;
		logic [16:0] len;
		logic [17:0] pstep;
		logic [30:0] tick;
		arst_n = 0;
		for (k = 0; k < VOICES; k++)
			v_act[k] = 0;

		// fill the playback window, wrapping past the top of memory
		for (off = 0; off < WIN_SIZE; off++)
			push_write(WIN_BASE + off, (off == 0) ? 8'hFF : (off == 1) ? 8'h00 : 8'($urandom));

		// directed: unknown request, zero length, length saturation, full voice set
		push_kind(REQ_NONE);
		push_start(8'd5, 1'b0, 0, 17'd0, 4'hF, 18'd0, 8'd0, 31'd10);
		push_kind(REQ_MIX);
		push_start(8'd5, 1'b0, 0, 17'h1FFFF, 4'hF, 18'd0, 8'hFF, 31'd20);
		for (k = 0; k < 7; k++)
			push_start(8'd6 + k, 1'b0, 0, 17'h10000, 4'hF, 18'd0, 8'(k * 40), 31'd20);
		push_kind(REQ_MIX);
		push_write(WIN_BASE, 8'h00);
		push_kind(REQ_MIX);
		push_start(8'd5, 1'b1, 1, 17'd3, 4'd7, 18'h10000, 8'd127, 31'd30);
		push_start(8'd9, 1'b0, 2, 17'd0, 4'd0, 18'd0, 8'd64, 31'd5);
		push_start(8'd200, 1'b1, 0, 17'd256, 4'hF, 18'h3FFFF, 8'd255, 31'h7FFFFFFF);
		push_kind(REQ_MIX);
		push_kind(REQ_MIX);
		push_write(16'h1234, 8'h5A);

		// random traffic
		for (k = 0; k < RAND_REQS; k++) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				push_write(($urandom_range(9) < 7) ? WIN_BASE + $urandom_range(WIN_SIZE - 1)
					: 16'($urandom), $urandom);
			end else if (pick < 55) begin
				off = $urandom_range(WIN_SIZE - 1);
				if ($urandom_range(9) == 0) begin
					pstep = 0;
					len = $urandom;
				end else begin
					len = $urandom_range(WIN_SIZE - off);
					pstep = $urandom_range(1) ? 18'($urandom_range(32'h30000)) : 18'($urandom);
				end
				if ($urandom_range(99) < 85) begin
					tick_now += $urandom_range(3);
					tick = tick_now;
				end else begin
					tick = $urandom;
				end
				push_start(($urandom_range(9) < 7) ? 8'($urandom_range(3)) : 8'($urandom),
					$urandom, off, len, $urandom, pstep, $urandom, tick);
			end else if (pick < 95) begin
				push_kind(REQ_MIX);
			end else begin
				push_kind(REQ_NONE);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1;
		while (req_q.size() > 0 || in_valid || frame_expect_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && frame_expect_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
+incdir+hdl
hdl/mpsm_pkg.sv
hdl/mpsm_ctrl.sv
hdl/mpsm_dp.sv
hdl/multichannel_pcm_sample_mixer.sv
bench/testbench.sv
